// ===== design/lbmc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the LED breathing mode controller.
// No dependencies; used by led_breathing_mode_controller.

package lbmc_pkg;

    localparam int LEVEL_W = 10;
    localparam int STEP_W  = 6;
    localparam int CFG_W   = 10;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_FAST = 2'd1,
        MODE_SLOW = 2'd2,
        MODE_FULL = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_SET_MODE = 2'd1,
        CMD_SET_APP  = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        APP_INIT    = 2'd0,
        APP_READY   = 2'd1,
        APP_PROBLEM = 2'd2,
        APP_OTHER   = 2'd3
    } app_t;

    typedef enum logic [1:0] {
        REG_MAX_LEVEL = 2'd0,
        REG_MIN_LEVEL = 2'd1,
        REG_RAMP_STEP = 2'd2,
        REG_UNUSED    = 2'd3
    } reg_idx_t;

    localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 10'd235;
    localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST = 10'd10;
    localparam logic [STEP_W-1:0]  RAMP_STEP_RST = 6'd4;
    localparam logic [LEVEL_W-1:0] LEVEL_RST     = 10'd235;
    localparam logic [LEVEL_W-1:0] FULL_DUTY     = 10'd1023;
    localparam logic [1:0]         FULL_HOLD     = 2'd2;
    localparam logic [1:0]         PRESC_FAST    = 2'b01;
    localparam logic [1:0]         PRESC_SLOW    = 2'b11;

endpackage

// ===== design/led_breathing_mode_controller.sv =====
`timescale 1ns / 1ps
// LED breathing mode controller: PWM duty and ramp prescaler for a status LED.
// Depends on lbmc_pkg.

// Each accepted item (tick, set mode, set application state) updates the
// mode, ramp and hold state in the cycle it is accepted and presents one
// result item (duty, prescaler code, current mode) on the next cycle. One item
// is accepted per cycle: the state update is an 11-bit add or 10-bit subtract
// with two compares, and the result register frees as it is taken, so input
// is held off only while a result waits and the master side is stalled.
// Configuration writes take effect at the clock edge where cfg_we is high.
module led_breathing_mode_controller
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [1:0] mode_request, [3:2] app_status, [7:4] zero
    input  logic [1:0]  s_tuser,    // [1:0] command
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // [9:0] duty, [11:10] prescale_code, [13:12] mode_now
);

    localparam int LW = lbmc_pkg::LEVEL_W;

    // configuration
    logic [LW-1:0]               max_level_reg;
    logic [LW-1:0]               min_level_reg;
    logic [lbmc_pkg::STEP_W-1:0] ramp_step_reg;

    // block state
    lbmc_pkg::mode_t mode_reg, mode_next;
    logic [LW-1:0]   level_reg, level_next;
    logic            rising_reg, rising_next;
    logic [1:0]      hold_reg, hold_next;
    logic [1:0]      sys_reg, sys_next;
    logic [LW-1:0]   duty_reg, duty_next;
    logic [1:0]      presc_reg, presc_next;
    logic            out_valid_reg;

    logic            accept;
    lbmc_pkg::cmd_t  cmd;
    logic [1:0]      req;
    logic [1:0]      app;

    logic            enter_en;
    lbmc_pkg::mode_t enter_mode;
    logic [LW:0]     sum;
    logic [LW-1:0]   diff;
    logic [LW-1:0]   step_ext;

    assign cmd      = lbmc_pkg::cmd_t'(s_tuser);
    assign req      = s_tdata[1:0];
    assign app      = s_tdata[3:2];
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign step_ext = LW'(ramp_step_reg);
    assign sum      = {1'b0, level_reg} + {1'b0, step_ext};
    assign diff     = (level_reg >= step_ext) ? (level_reg - step_ext) : '0;

    always_comb
    begin
        mode_next   = mode_reg;
        level_next  = level_reg;
        rising_next = rising_reg;
        hold_next   = hold_reg;
        sys_next    = sys_reg;
        duty_next   = duty_reg;
        presc_next  = presc_reg;
        enter_en    = 1'b0;
        enter_mode  = mode_reg;

        unique case (cmd)
            lbmc_pkg::CMD_TICK:
            begin
                if (mode_reg == lbmc_pkg::MODE_FAST || mode_reg == lbmc_pkg::MODE_SLOW)
                begin
                    if (rising_reg)
                    begin
                        if (sum >= {1'b0, max_level_reg})
                        begin
                            level_next  = max_level_reg;
                            rising_next = 1'b0;
                        end
                        else
                        begin
                            level_next = sum[LW-1:0];
                        end
                    end
                    else
                    begin
                        if (diff <= min_level_reg)
                        begin
                            level_next  = min_level_reg;
                            rising_next = 1'b1;
                        end
                        else
                        begin
                            level_next = diff;
                        end
                    end
                    duty_next = level_next;
                end
                if (mode_reg == lbmc_pkg::MODE_FULL)
                begin
                    hold_next = hold_reg - 2'd1;
                    if (hold_next == 2'd0)
                    begin
                        // hold expired: follow the application state
                        enter_en = 1'b1;
                        case (lbmc_pkg::app_t'(sys_reg))
                            lbmc_pkg::APP_INIT:    enter_mode = lbmc_pkg::MODE_FAST;
                            lbmc_pkg::APP_READY:   enter_mode = lbmc_pkg::MODE_SLOW;
                            lbmc_pkg::APP_PROBLEM: enter_mode = lbmc_pkg::MODE_OFF;
                            default:               enter_mode = lbmc_pkg::MODE_FULL;
                        endcase
                    end
                end
            end
            lbmc_pkg::CMD_SET_MODE:
            begin
                enter_en   = 1'b1;
                enter_mode = lbmc_pkg::mode_t'(req);
            end
            lbmc_pkg::CMD_SET_APP:
            begin
                sys_next = app;
            end
            default:
            begin
                // unused command: hold everything
            end
        endcase

        if (enter_en)
        begin
            mode_next = enter_mode;
            unique case (enter_mode)
                lbmc_pkg::MODE_OFF:
                begin
                    duty_next = '0;
                end
                lbmc_pkg::MODE_FULL:
                begin
                    duty_next = lbmc_pkg::FULL_DUTY;
                    hold_next = lbmc_pkg::FULL_HOLD;
                end
                lbmc_pkg::MODE_FAST:
                begin
                    presc_next  = lbmc_pkg::PRESC_FAST;
                    duty_next   = max_level_reg;
                    rising_next = 1'b0;
                end
                default:
                begin
                    presc_next  = lbmc_pkg::PRESC_SLOW;
                    duty_next   = max_level_reg;
                    rising_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_level_reg <= lbmc_pkg::MAX_LEVEL_RST;
            min_level_reg <= lbmc_pkg::MIN_LEVEL_RST;
            ramp_step_reg <= lbmc_pkg::RAMP_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (lbmc_pkg::reg_idx_t'(cfg_index))
                lbmc_pkg::REG_MAX_LEVEL: max_level_reg <= cfg_data[LW-1:0];
                lbmc_pkg::REG_MIN_LEVEL: min_level_reg <= cfg_data[LW-1:0];
                lbmc_pkg::REG_RAMP_STEP: ramp_step_reg <= cfg_data[lbmc_pkg::STEP_W-1:0];
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= lbmc_pkg::MODE_OFF;
            level_reg     <= lbmc_pkg::LEVEL_RST;
            rising_reg    <= 1'b0;
            hold_reg      <= 2'd0;
            sys_reg       <= 2'd0;
            duty_reg      <= '0;
            presc_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg   <= mode_next;
                level_reg  <= level_next;
                rising_reg <= rising_next;
                hold_reg   <= hold_next;
                sys_reg    <= sys_next;
                duty_reg   <= duty_next;
                presc_reg  <= presc_next;
            end
            // result stays up until taken; a new item refills it in the same cycle
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // state only changes on accept, which needs the result slot free or being taken
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, mode_reg, presc_reg, duty_reg};

endmodule
